>>> design/tdsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdsc_pkg
// Shared widths, register map and period code table of the TDD slot
// direction classifier.
// ----------------------------------------------------------------------------
package tdsc_pkg;

  localparam int SLOT_W      = 18;
  localparam int CODE_W      = 3;
  localparam int NUM_W       = 3;
  localparam int DL_SLOTS_W  = 9;
  localparam int DL_SYMS_W   = 4;
  localparam int EIGHTHS_W   = 7;
  localparam int ESUM_W      = EIGHTHS_W + 1;
  localparam int WIDE_W      = 13;
  localparam int P1_W        = 8;
  localparam int REM_W       = 9;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int DIV_BITS    = 3;
  localparam int DIV_STAGES  = SLOT_W / DIV_BITS;

  localparam logic [NUM_W-1:0]   NUM_MAX    = 3'd4;
  localparam logic [P1_W-1:0]    P1_RST     = 8'd10;
  localparam logic [REM_W-1:0]   TOTAL_RST  = 9'd10;
  localparam logic [CODE_W-1:0]  CODE_RST   = 3'd7;
  localparam logic [WIDE_W-1:0]  ROUND_HALF = 13'd4;

  typedef enum logic [2:0] {
    REG_FIRST_PERIOD  = 3'd0,
    REG_SECOND_PRES   = 3'd1,
    REG_SECOND_PERIOD = 3'd2,
    REG_FIRST_DL_SLOT = 3'd3,
    REG_FIRST_DL_SYM  = 3'd4,
    REG_SECOND_DL_SLOT = 3'd5,
    REG_SECOND_DL_SYM = 3'd6,
    REG_NUMEROLOGY    = 3'd7
  } reg_idx_t;

  // period code to eighths of a millisecond
  function automatic logic [EIGHTHS_W-1:0] eighths_of(input logic [CODE_W-1:0] code);
    logic [EIGHTHS_W-1:0] e;
    case (code)
      3'd0:    e = 7'd4;
      3'd1:    e = 7'd5;
      3'd2:    e = 7'd8;
      3'd3:    e = 7'd10;
      3'd4:    e = 7'd16;
      3'd5:    e = 7'd20;
      3'd6:    e = 7'd40;
      default: e = 7'd80;
    endcase
    return e;
  endfunction

endpackage

>>> design/tdd_slot_direction_classifier.sv
`timescale 1ns / 1ps
// path: from input acceptance to out_valid through 6 modulo stages, the first loaded at
// acceptance, then 1 classify stage
// throughput: one word per cycle unless out_ready stalls; 6-stage restoring modulo, 3 bits a stage
// the input pauses in the cycle after each register write while the period is recomputed
// reset: synchronous active-low rst_n clears the pipeline and sets both period codes to 7,
// pattern 1 length and total period to 10, the other configuration registers to 0
// ----------------------------------------------------------------------------
// tdd_slot_direction_classifier
// Reduces a slot number modulo the configured TDD period and reports
// whether the slot is downlink or uplink.
// ----------------------------------------------------------------------------
module tdd_slot_direction_classifier
  import tdsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [SLOT_W-1:0] in_slot_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_downlink,
  output logic              out_is_uplink,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CODE_W-1:0]     first_period_r;
  logic                  second_present_r;
  logic [CODE_W-1:0]     second_period_r;
  logic [DL_SLOTS_W-1:0] first_dl_slots_r;
  logic [DL_SYMS_W-1:0]  first_dl_syms_r;
  logic [DL_SLOTS_W-1:0] second_dl_slots_r;
  logic [DL_SYMS_W-1:0]  second_dl_syms_r;
  logic [NUM_W-1:0]      numerology_r;
  logic                  cfg_hold_r;

  logic [P1_W-1:0]       p1_r, p1_nxt;
  logic [REM_W-1:0]      total_r, total_nxt;

  logic                  cfg_wr;
  reg_idx_t              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_period_r    <= CODE_RST;
      second_present_r  <= 1'b0;
      second_period_r   <= CODE_RST;
      first_dl_slots_r  <= '0;
      first_dl_syms_r   <= '0;
      second_dl_slots_r <= '0;
      second_dl_syms_r  <= '0;
      numerology_r      <= '0;
      cfg_hold_r        <= 1'b0;
    end else begin
      cfg_hold_r <= cfg_wr;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_FIRST_PERIOD:   first_period_r    <= pwdata[CODE_W-1:0];
          REG_SECOND_PRES:    second_present_r  <= pwdata[0];
          REG_SECOND_PERIOD:  second_period_r   <= pwdata[CODE_W-1:0];
          REG_FIRST_DL_SLOT:  first_dl_slots_r  <= pwdata[DL_SLOTS_W-1:0];
          REG_FIRST_DL_SYM:   first_dl_syms_r   <= pwdata[DL_SYMS_W-1:0];
          REG_SECOND_DL_SLOT: second_dl_slots_r <= pwdata[DL_SLOTS_W-1:0];
          REG_SECOND_DL_SYM:  second_dl_syms_r  <= pwdata[DL_SYMS_W-1:0];
          REG_NUMEROLOGY:     numerology_r      <= pwdata[NUM_W-1:0];
        endcase
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_FIRST_PERIOD:   prdata[CODE_W-1:0]     = first_period_r;
      REG_SECOND_PRES:    prdata[0]              = second_present_r;
      REG_SECOND_PERIOD:  prdata[CODE_W-1:0]     = second_period_r;
      REG_FIRST_DL_SLOT:  prdata[DL_SLOTS_W-1:0] = first_dl_slots_r;
      REG_FIRST_DL_SYM:   prdata[DL_SYMS_W-1:0]  = first_dl_syms_r;
      REG_SECOND_DL_SLOT: prdata[DL_SLOTS_W-1:0] = second_dl_slots_r;
      REG_SECOND_DL_SYM:  prdata[DL_SYMS_W-1:0]  = second_dl_syms_r;
      REG_NUMEROLOGY:     prdata[NUM_W-1:0]      = numerology_r;
    endcase
  end

  // pattern 1 length and total period in slots
  logic [NUM_W-1:0]     mu_eff;
  logic [EIGHTHS_W-1:0] e1, e2;
  logic [ESUM_W-1:0]    esum;
  logic [WIDE_W-1:0]    p1_wide, total_wide;

  always_comb begin
    mu_eff     = (numerology_r > NUM_MAX) ? NUM_MAX : numerology_r;
    e1         = eighths_of(first_period_r);
    e2         = second_present_r ? eighths_of(second_period_r) : '0;
    esum       = {1'b0, e1} + {1'b0, e2};
    p1_wide    = WIDE_W'(e1) << mu_eff;
    total_wide = (WIDE_W'(esum) << mu_eff) + ROUND_HALF;
    p1_nxt     = p1_wide[P1_W+2:3];
    total_nxt  = total_wide[REM_W+2:3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r    <= P1_RST;
      total_r <= TOTAL_RST;
    end else begin
      p1_r    <= p1_nxt;
      total_r <= total_nxt;
    end
  end

  // restoring modulo pipeline
  function automatic logic [REM_W-1:0] mod_step(input logic [REM_W-1:0] rem,
                                                input logic             b,
                                                input logic [REM_W-1:0] tot);
    logic [REM_W:0] t;
    t = {rem, b};
    if (t >= {1'b0, tot}) t = t - {1'b0, tot};
    return t[REM_W-1:0];
  endfunction

  logic [DIV_STAGES-1:0] vld_r;
  logic [REM_W-1:0]      rem_r   [DIV_STAGES];
  logic [SLOT_W-1:0]     slot_r  [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_nxt;
  logic [REM_W-1:0]      rem_nxt [DIV_STAGES];
  logic [SLOT_W-1:0]     slot_nxt[DIV_STAGES];
  logic [DIV_STAGES-1:0] stg_rdy;
  logic                  res_rdy;
  logic                  out_valid_r;
  logic                  out_dl_r;

  assign res_rdy  = !out_valid_r || out_ready;
  assign in_ready = stg_rdy[0] && !cfg_hold_r;

  always_comb begin
    stg_rdy[DIV_STAGES-1] = !vld_r[DIV_STAGES-1] || res_rdy;
    for (int k = DIV_STAGES - 2; k >= 0; k--) begin
      stg_rdy[k] = !vld_r[k] || stg_rdy[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        vld_nxt[k]  = in_valid && in_ready;
        slot_nxt[k] = in_slot_count;
        rem_nxt[k]  = '0;
      end else begin
        vld_nxt[k]  = vld_r[k-1];
        slot_nxt[k] = slot_r[k-1];
        rem_nxt[k]  = rem_r[k-1];
      end
      for (int j = 0; j < DIV_BITS; j++) begin
        rem_nxt[k] = mod_step(rem_nxt[k], slot_nxt[k][SLOT_W-1-k*DIV_BITS-j], total_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (stg_rdy[k]) vld_r[k] <= vld_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (stg_rdy[k] && vld_nxt[k]) begin
        rem_r[k]  <= rem_nxt[k];
        slot_r[k] <= slot_nxt[k];
      end
    end
  end

  // pattern select and direction
  logic [REM_W-1:0]      idx, idx_sel;
  logic                  use_second;
  logic [DL_SLOTS_W-1:0] dl_slots;
  logic [DL_SYMS_W-1:0]  dl_syms;
  logic                  dl;

  always_comb begin
    idx        = rem_r[DIV_STAGES-1];
    use_second = idx >= {1'b0, p1_r};
    idx_sel    = use_second ? idx - {1'b0, p1_r} : idx;
    dl_slots   = use_second ? second_dl_slots_r : first_dl_slots_r;
    dl_syms    = use_second ? second_dl_syms_r  : first_dl_syms_r;
    dl         = (idx_sel < dl_slots) || ((idx_sel == dl_slots) && (dl_syms != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_rdy) begin
      out_valid_r <= vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (res_rdy && vld_r[DIV_STAGES-1]) out_dl_r <= dl;
  end

  assign out_valid       = out_valid_r;
  assign out_is_downlink = out_dl_r;
  assign out_is_uplink   = !out_dl_r;

endmodule

>>> design/tdsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdsc_checker
// Port-level checks of the TDD slot direction classifier, bound to the
// top level.
// ----------------------------------------------------------------------------
module tdsc_checker
  import tdsc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_is_downlink,
  input logic              out_is_uplink,
  input logic              pready,
  input logic [DATA_W-1:0] prdata
);

  // directions are exclusive
  a_dir_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_uplink != out_is_downlink))
    else $error("uplink and downlink flags not complementary");

  // a word waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output word dropped before acceptance");

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  // no wait states and no stray read bits
  a_apb_read: assert property (@(posedge clk) disable iff (!rst_n)
    pready && (prdata[DATA_W-1:DL_SLOTS_W] == '0))
    else $error("bad register port response");

endmodule

bind tdd_slot_direction_classifier tdsc_checker u_tdsc_checker (.*);
